// ===== design/dtpu_pkg.sv =====
package dtpu_pkg;

    typedef struct packed {
        logic [9:0]         column;
        logic [8:0]         row;
        logic signed [15:0] disparity;
        logic [7:0]         gray;
    } t_in_word;

    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic [22:0]        point_z;
        logic               point_valid;
        logic               in_window;
        logic [7:0]         gray_out;
    } t_out_word;

    localparam logic [2:0] CFG_BASELINE_FOCAL = 3'd0;
    localparam logic [2:0] CFG_CENTER_X       = 3'd1;
    localparam logic [2:0] CFG_CENTER_Y       = 3'd2;
    localparam logic [2:0] CFG_FOCAL_X        = 3'd3;
    localparam logic [2:0] CFG_FOCAL_Y        = 3'd4;
    localparam logic [2:0] CFG_BORDER         = 3'd5;
    localparam logic [2:0] CFG_MIN_DISPARITY  = 3'd6;

    localparam int Z_W    = 36;
    localparam int PROD_W = 50;
    localparam int HALF_W = 18;

    // control carried alongside the depth divider
    typedef struct packed {
        logic signed [14:0] off_x;
        logic signed [14:0] off_y;
        logic               valid;
        logic               inwin;
        logic [7:0]         gray;
    } t_depth_ctl;

    // control carried alongside the lateral divider
    typedef struct packed {
        logic        neg_x;
        logic [22:0] pz;
        logic        valid;
        logic        inwin;
        logic [7:0]  gray;
    } t_coord_ctl;

    localparam logic [22:0] Z_MAX = 23'h7FFFFF;

endpackage

// ===== design/disparity_to_point_unproject_core.sv =====
// From input word to output word: 1 window stage, 36 depth divider stages,
// 2 multiply stages, 50 coordinate divider stages, 1 output register.
// Throughput: one word per cycle; the bit-per-stage dividers set the depth.
// A stall at the output freezes the whole pipeline.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults.
module disparity_to_point_unproject_core #(
    parameter int IMG_WIDTH  = 640,
    parameter int IMG_HEIGHT = 480
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  dtpu_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output dtpu_pkg::t_out_word  o_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int PW1 = $bits(dtpu_pkg::t_depth_ctl);
    localparam int PW2 = $bits(dtpu_pkg::t_coord_ctl);

    logic [31:0] r_baseline;
    logic [13:0] r_cx, r_cy;
    logic [15:0] r_fx, r_fy;
    logic [7:0]  r_border;
    logic [14:0] r_min_disp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= 32'd3407872;
            r_cx       <= 14'd5120;
            r_cy       <= 14'd3840;
            r_fx       <= 16'd6960;
            r_fy       <= 16'd6960;
            r_border   <= 8'd64;
            r_min_disp <= 15'd96;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dtpu_pkg::CFG_BASELINE_FOCAL: r_baseline <= i_cfg_data;
                dtpu_pkg::CFG_CENTER_X:       r_cx       <= i_cfg_data[13:0];
                dtpu_pkg::CFG_CENTER_Y:       r_cy       <= i_cfg_data[13:0];
                dtpu_pkg::CFG_FOCAL_X:        r_fx       <= i_cfg_data[15:0];
                dtpu_pkg::CFG_FOCAL_Y:        r_fy       <= i_cfg_data[15:0];
                dtpu_pkg::CFG_BORDER:         r_border   <= i_cfg_data[7:0];
                dtpu_pkg::CFG_MIN_DISPARITY:  r_min_disp <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_out_valid;
    dtpu_pkg::t_out_word r_out;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // window and threshold stage
    logic [13:0] col_end, row_end;
    logic [14:0] thr;
    logic        inwin, pvalid;
    dtpu_pkg::t_depth_ctl n_a;
    dtpu_pkg::t_depth_ctl r_a;
    logic        r_a_valid;
    logic [14:0] r_a_den;

    always_comb begin
        col_end = 14'(i_data.column) + 14'(r_border);
        row_end = 14'(i_data.row) + 14'(r_border);
        thr     = (r_min_disp == '0) ? 15'd1 : r_min_disp;
        inwin   = (14'(i_data.column) >= 14'(r_border))
                  && (col_end < 14'(IMG_WIDTH))
                  && (14'(i_data.row) >= 14'(r_border))
                  && (row_end < 14'(IMG_HEIGHT));
        pvalid  = inwin && !i_data.disparity[15] && (i_data.disparity[14:0] >= thr);
        n_a.off_x = 15'({1'b0, i_data.column, 4'b0}) - 15'({1'b0, r_cx});
        n_a.off_y = 15'({2'b0, i_data.row, 4'b0}) - 15'({1'b0, r_cy});
        n_a.valid = pvalid;
        n_a.inwin = inwin;
        n_a.gray  = i_data.gray;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a     <= n_a;
            r_a_den <= pvalid ? i_data.disparity[14:0] : 15'd1;
        end
    end

    // depth
    logic                    d1_valid;
    logic [dtpu_pkg::Z_W-1:0] d1_z;
    logic [PW1-1:0]          d1_pay;

    dtpu_div #(.NW(dtpu_pkg::Z_W), .DW(15), .PW(PW1)) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_valid),
        .i_num   ({r_baseline, 4'b0}),
        .i_den   (r_a_den),
        .i_pay   (r_a),
        .o_valid (d1_valid),
        .o_quo   (d1_z),
        .o_pay   (d1_pay)
    );

    logic                          m_valid;
    logic [dtpu_pkg::PROD_W-1:0]   m_px, m_py;
    dtpu_pkg::t_coord_ctl          m_ctl;
    logic                          m_neg_y;

    dtpu_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (d1_valid),
        .i_z      (d1_z),
        .i_ctl    (dtpu_pkg::t_depth_ctl'(d1_pay)),
        .o_valid  (m_valid),
        .o_prod_x (m_px),
        .o_prod_y (m_py),
        .o_ctl    (m_ctl),
        .o_neg_y  (m_neg_y)
    );

    logic [15:0] fx_d, fy_d;
    assign fx_d = (r_fx == '0) ? 16'd1 : r_fx;
    assign fy_d = (r_fy == '0) ? 16'd1 : r_fy;

    logic                          dx_valid, dy_valid;
    logic [dtpu_pkg::PROD_W-1:0]   qx, qy;
    logic [PW2-1:0]                dx_pay;
    logic [0:0]                    dy_pay;

    dtpu_div #(.NW(dtpu_pkg::PROD_W), .DW(16), .PW(PW2)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (m_valid),
        .i_num   (m_px),
        .i_den   (fx_d),
        .i_pay   (m_ctl),
        .o_valid (dx_valid),
        .o_quo   (qx),
        .o_pay   (dx_pay)
    );

    dtpu_div #(.NW(dtpu_pkg::PROD_W), .DW(16), .PW(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (m_valid),
        .i_num   (m_py),
        .i_den   (fy_d),
        .i_pay   (m_neg_y),
        .o_valid (dy_valid),
        .o_quo   (qy),
        .o_pay   (dy_pay)
    );

    // saturate and output register
    dtpu_pkg::t_coord_ctl fc;
    dtpu_pkg::t_out_word  n_out;
    logic signed [23:0]   sx, sy;

    localparam logic [dtpu_pkg::PROD_W-1:0] POS_MAX = dtpu_pkg::PROD_W'(24'h7FFFFF);
    localparam logic [dtpu_pkg::PROD_W-1:0] NEG_MAX = dtpu_pkg::PROD_W'(25'h0800000);

    always_comb begin
        fc = dtpu_pkg::t_coord_ctl'(dx_pay);
        if (fc.neg_x) begin
            sx = (qx > NEG_MAX) ? 24'sh800000 : 24'(-qx[23:0]);
        end else begin
            sx = (qx > POS_MAX) ? 24'sh7FFFFF : 24'(qx[23:0]);
        end
        if (dy_pay[0]) begin
            sy = (qy > NEG_MAX) ? 24'sh800000 : 24'(-qy[23:0]);
        end else begin
            sy = (qy > POS_MAX) ? 24'sh7FFFFF : 24'(qy[23:0]);
        end
        n_out.point_x     = fc.valid ? sx : '0;
        n_out.point_y     = fc.valid ? sy : '0;
        n_out.point_z     = fc.valid ? fc.pz : '0;
        n_out.point_valid = fc.valid;
        n_out.in_window   = fc.inwin;
        n_out.gray_out    = fc.inwin ? fc.gray : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dx_valid && dy_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== design/dtpu_div.sv =====
module dtpu_div #(
    parameter int NW = 36,
    parameter int DW = 16,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    logic          r_vld [NW];
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_nq  [NW];
    logic [DW-1:0] r_den [NW];
    logic [PW-1:0] r_pay [NW];

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          vin;
        logic [DW-1:0] rin;
        logic [NW-1:0] qin;
        logic [DW-1:0] din;
        logic [PW-1:0] pin;
        logic [DW:0]   t;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [NW-1:0] n_nq;

        if (k == 0) begin : g_first
            assign vin = i_valid;
            assign rin = '0;
            assign qin = i_num;
            assign din = i_den;
            assign pin = i_pay;
        end else begin : g_next
            assign vin = r_vld[k-1];
            assign rin = r_rem[k-1];
            assign qin = r_nq[k-1];
            assign din = r_den[k-1];
            assign pin = r_pay[k-1];
        end

        always_comb begin
            t     = {rin, qin[NW-1]};
            ge    = t >= {1'b0, din};
            n_rem = ge ? DW'(t - {1'b0, din}) : t[DW-1:0];
            n_nq  = {qin[NW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_nq[k]  <= n_nq;
                r_den[k] <= din;
                r_pay[k] <= pin;
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_nq[NW-1];
    assign o_pay   = r_pay[NW-1];

endmodule

// ===== design/dtpu_mul.sv =====
module dtpu_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [dtpu_pkg::Z_W-1:0]     i_z,
    input  dtpu_pkg::t_depth_ctl         i_ctl,
    output logic                         o_valid,
    output logic [dtpu_pkg::PROD_W-1:0]  o_prod_x,
    output logic [dtpu_pkg::PROD_W-1:0]  o_prod_y,
    output dtpu_pkg::t_coord_ctl         o_ctl,
    output logic                         o_neg_y
);

    localparam int HW = dtpu_pkg::HALF_W;
    localparam int PW = dtpu_pkg::PROD_W;

    logic [13:0] mag_x;
    logic [13:0] mag_y;
    logic [14:0] abs_x;
    logic [14:0] abs_y;

    logic                r_v1;
    logic [HW+13:0]      r_xl, r_xh, r_yl, r_yh;
    dtpu_pkg::t_coord_ctl r_c1;
    logic                r_ny1;

    logic                r_v2;
    logic [PW-1:0]       r_px, r_py;
    dtpu_pkg::t_coord_ctl r_c2;
    logic                r_ny2;

    always_comb begin
        abs_x = i_ctl.off_x[14] ? 15'(-i_ctl.off_x) : 15'(i_ctl.off_x);
        abs_y = i_ctl.off_y[14] ? 15'(-i_ctl.off_y) : 15'(i_ctl.off_y);
        mag_x = abs_x[13:0];
        mag_y = abs_y[13:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xl        <= mag_x * i_z[HW-1:0];
            r_xh        <= mag_x * i_z[2*HW-1:HW];
            r_yl        <= mag_y * i_z[HW-1:0];
            r_yh        <= mag_y * i_z[2*HW-1:HW];
            r_c1.neg_x  <= i_ctl.off_x[14];
            r_c1.pz     <= (i_z > dtpu_pkg::Z_W'(dtpu_pkg::Z_MAX)) ? dtpu_pkg::Z_MAX
                                                                 : i_z[22:0];
            r_c1.valid  <= i_ctl.valid;
            r_c1.inwin  <= i_ctl.inwin;
            r_c1.gray   <= i_ctl.gray;
            r_ny1       <= i_ctl.off_y[14];

            r_px  <= {r_xh, {HW{1'b0}}} + PW'(r_xl);
            r_py  <= {r_yh, {HW{1'b0}}} + PW'(r_yl);
            r_c2  <= r_c1;
            r_ny2 <= r_ny1;
        end
    end

    assign o_valid  = r_v2;
    assign o_prod_x = r_px;
    assign o_prod_y = r_py;
    assign o_ctl    = r_c2;
    assign o_neg_y  = r_ny2;

endmodule
